/* rtl/core/lpd_pkg.sv */
`default_nettype none

package lpd_pkg;

  // header byte positions
  localparam logic [2:0] HDR_ID_HI  = 3'd0;
  localparam logic [2:0] HDR_ID_LO  = 3'd1;
  localparam logic [2:0] HDR_LEN_B3 = 3'd2;
  localparam logic [2:0] HDR_LEN_B2 = 3'd3;
  localparam logic [2:0] HDR_LEN_B1 = 3'd4;
  localparam logic [2:0] HDR_LEN_B0 = 3'd5;

  // one result item
  typedef struct packed {
    logic        empty_body;
    logic        last;
    logic [7:0]  body_byte;
    logic [15:0] msg_id;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/length_prefixed_deframer.sv */
// results are registered in the output register, or the skid entry on a stall
// throughput: one byte per cycle; a stalled output keeps accepting one more
// byte into the skid entry, then s_axis_tready drops until it drains
// reset: rst (synchronous) returns the parser to the start of a header and
// empties the output register and skid entry
`default_nettype none

module length_prefixed_deframer
  import lpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] clear
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] msg_id, [23:16] body_byte
  output logic             m_axis_tlast,   // last
  output logic             m_axis_tuser    // [0] empty_body
);

  logic take;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign take = s_axis_tvalid && s_axis_tready;

  // header parsing and body tagging
  lpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (s_axis_tdata),
    .clear     (s_axis_tuser),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register and skid entry
  lpd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {out_res.body_byte, out_res.msg_id};
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.empty_body;

  // an empty frame result is always the last of its frame
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[23:16] == 8'h00))
    else $error("empty frame result not marked last");

endmodule

`default_nettype wire

/* rtl/core/lpd_parser.sv */
`default_nettype none

module lpd_parser
  import lpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  input  wire logic       clear,
  output logic            res_valid,
  output res_t            res
);

  logic        in_body, in_body_next;
  logic [2:0]  header_count, header_count_next;
  logic [15:0] frame_id, frame_id_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] len_full;

  // length with the final header byte shifted in
  assign len_full = {remaining[23:0], rx_byte};

  // next state and result for the item at the input
  always_comb begin
    in_body_next      = in_body;
    header_count_next = header_count;
    frame_id_next     = frame_id;
    remaining_next    = remaining;
    res_valid         = 1'b0;
    res.msg_id        = frame_id;
    res.body_byte     = rx_byte;
    res.last          = (remaining == 32'd1);
    res.empty_body    = 1'b0;
    if (take) begin
      if (clear) begin
        in_body_next      = 1'b0;
        header_count_next = HDR_ID_HI;
        frame_id_next     = '0;
        remaining_next    = '0;
      end else if (in_body) begin
        res_valid      = 1'b1;
        remaining_next = remaining - 32'd1;
        if (remaining == 32'd1) begin
          in_body_next      = 1'b0;
          header_count_next = HDR_ID_HI;
        end
      end else begin
        case (header_count)
          HDR_ID_HI: begin
            frame_id_next     = {rx_byte, 8'h00};
            header_count_next = HDR_ID_LO;
          end
          HDR_ID_LO: begin
            frame_id_next     = {frame_id[15:8], rx_byte};
            header_count_next = HDR_LEN_B3;
          end
          HDR_LEN_B3: begin
            remaining_next    = {24'h0, rx_byte};
            header_count_next = HDR_LEN_B2;
          end
          HDR_LEN_B2, HDR_LEN_B1: begin
            remaining_next    = len_full;
            header_count_next = header_count + 3'd1;
          end
          default: begin
            // final length byte; a zero length gives one empty result
            remaining_next    = len_full;
            header_count_next = HDR_ID_HI;
            if (len_full == 32'd0) begin
              res_valid      = 1'b1;
              res.body_byte  = 8'h00;
              res.last       = 1'b1;
              res.empty_body = 1'b1;
            end else begin
              in_body_next = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_body      <= 1'b0;
      header_count <= HDR_ID_HI;
      frame_id     <= '0;
      remaining    <= '0;
    end else begin
      in_body      <= in_body_next;
      header_count <= header_count_next;
      frame_id     <= frame_id_next;
      remaining    <= remaining_next;
    end
  end

  // body state always has bytes left and a reset header count
  a_body_has_bytes: assert property (@(posedge clk) disable iff (rst)
    in_body |-> (remaining != 32'd0) && (header_count == HDR_ID_HI))
    else $error("body state with no bytes left");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= HDR_LEN_B0)
    else $error("header count out of range");

  // a body byte that closes the frame returns to header parsing
  a_last_ends_body: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last && !res.empty_body |=> !in_body)
    else $error("body did not end after last byte");

endmodule

`default_nettype wire

/* rtl/core/lpd_skid.sv */
`default_nettype none

module lpd_skid
  import lpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire res_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  logic buf_valid;
  res_t buf_data;

  assign in_ready = !buf_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      buf_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (buf_valid) begin
        out_valid <= 1'b1;
        buf_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !buf_valid) begin
      buf_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= buf_valid ? buf_data : in_data;
    end
    if (in_valid && !buf_valid && out_valid && !out_ready) begin
      buf_data <= in_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> out_valid)
    else $error("skid entry held without output item");

endmodule

`default_nettype wire

/* tb/length_prefixed_deframer_tb.sv */
`timescale 1ns / 1ps

module length_prefixed_deframer_tb;
  import lpd_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int TARGET_BYTES = 1450;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  // frame parser mirror and queue of expected output items
  class deframe_scoreboard;
    logic        in_body;
    logic [2:0]  hdr_pos;
    logic [15:0] frame_id;
    logic [31:0] bytes_left;
    res_t        expected_q[$];
    int          n_checked;
    int          n_errors;
    int          n_frames;
    int          n_empty;

    function new();
      clear_parser();
      n_checked = 0;
      n_errors  = 0;
      n_frames  = 0;
      n_empty   = 0;
    endfunction

    function void clear_parser();
      in_body    = 1'b0;
      hdr_pos    = HDR_ID_HI;
      frame_id   = 16'h0000;
      bytes_left = 32'd0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted input item
    function void note_byte(logic [7:0] b, logic clr);
      res_t r;
      if (clr) begin
        clear_parser();
        return;
      end
      // body byte passes through tagged with the frame id
      if (in_body) begin
        r.msg_id     = frame_id;
        r.body_byte  = b;
        r.last       = (bytes_left == 32'd1);
        r.empty_body = 1'b0;
        expected_q.push_back(r);
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          in_body = 1'b0;
          hdr_pos = HDR_ID_HI;
        end
        return;
      end
      // header bytes, all big-endian
      case (hdr_pos)
        HDR_ID_HI: begin
          frame_id = {b, 8'h00};
          hdr_pos  = HDR_ID_LO;
        end
        HDR_ID_LO: begin
          frame_id[7:0] = b;
          hdr_pos       = HDR_LEN_B3;
        end
        HDR_LEN_B3: begin
          bytes_left = {24'd0, b};
          hdr_pos    = HDR_LEN_B2;
        end
        HDR_LEN_B2, HDR_LEN_B1: begin
          bytes_left = {bytes_left[23:0], b};
          hdr_pos    = hdr_pos + 3'd1;
        end
        default: begin
          bytes_left = {bytes_left[23:0], b};
          hdr_pos    = HDR_ID_HI;
          if (bytes_left == 32'd0) begin
            r.msg_id     = frame_id;
            r.body_byte  = 8'h00;
            r.last       = 1'b1;
            r.empty_body = 1'b1;
            expected_q.push_back(r);
          end else begin
            in_body = 1'b1;
          end
        end
      endcase
    endfunction

    // one accepted output item against the oldest expectation
    function void check_result(logic [23:0] data, logic lst, logic emp);
      res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output item id=%h byte=%h last=%b empty=%b",
                 $time, data[15:0], data[23:16], lst, emp);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (lst) n_frames++;
      if (emp) n_empty++;
      if (data[15:0] !== e.msg_id) begin
        $display("%0t: msg_id mismatch, expected %h actual %h", $time, e.msg_id, data[15:0]);
        n_errors++;
      end
      if (data[23:16] !== e.body_byte) begin
        $display("%0t: body_byte mismatch, expected %h actual %h",
                 $time, e.body_byte, data[23:16]);
        n_errors++;
      end
      if (lst !== e.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, e.last, lst);
        n_errors++;
      end
      if (emp !== e.empty_body) begin
        $display("%0t: empty_body mismatch, expected %b actual %b",
                 $time, e.empty_body, emp);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0;    // [0] clear
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [15:0] msg_id, [23:16] body_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;           // [0] empty_body

  deframe_scoreboard sb = new();

  bit tx_no_gap   = 1'b0;
  bit rx_no_stall = 1'b0;
  bit hold_req    = 1'b0;
  int bytes_sent  = 0;
  int clears_sent = 0;

  length_prefixed_deframer DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // handshake monitor, inputs noted before outputs checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast,
                                                          m_axis_tuser);
    end
  end

  // watchdog on cycles with no progress
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout at %0t with %0d items outstanding", $time, sb.pending());
    $display("Verification failed");
    $finish;
  end

  // output side: random stalls per item, one long hold on request
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_no_stall ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // one input item after a random gap
  task automatic send_item(input logic [7:0] b, input logic clr);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= clr;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (clr) clears_sent++;
    else bytes_sent++;
  endtask

  // header plus body; a non-negative cut position below the frame size aborts it with a clear
  task automatic send_frame(input logic [15:0] id, input logic [31:0] len,
                            input longint cut);
    logic [47:0] hdr;
    longint      total;
    longint      k;
    logic [7:0]  b;
    hdr   = {id, len};
    total = 64'd6 + len;
    for (k = 0; k < total; k++) begin
      if (k == cut) break;
      if (k < 6) b = 8'(hdr >> (8 * (5 - k)));
      else b = 8'($urandom_range(0, 255));
      send_item(b, 1'b0);
    end
    if (cut >= 0 && cut < total) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // drop valid and let the monitor note the last accepted input, then wait for no pending items
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int          sel;
    int          pick;
    logic [31:0] len;
    bit          paused;
    paused = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty body, single byte body, aborted header, huge length aborted
    send_frame(16'hFFFF, 32'd0, -1);
    send_frame(16'h0000, 32'd1, -1);
    send_frame(16'h1234, 32'd5, 3);
    send_frame(16'h8001, 32'hFFFF_FFFF, 8);
    send_item(8'hFF, 1'b1);

    // sender waits for the output to empty, then a long output hold
    wait_drained();
    tx_no_gap = 1'b1;
    hold_req  = 1'b1;
    send_frame(16'($urandom()), 32'd60, -1);
    tx_no_gap = 1'b0;

    // random frames, with some noise and aborted frames
    while (bytes_sent < TARGET_BYTES) begin
      if ($urandom_range(0, 9) == 0) tx_no_gap = ~tx_no_gap;
      if ($urandom_range(0, 9) == 0) rx_no_stall = ~rx_no_stall;
      if (!paused && bytes_sent > TARGET_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (sel < 18) begin
        if ($urandom_range(0, 2) == 0) begin
          send_frame(16'($urandom()), $urandom(), $urandom_range(6, 12));
        end else begin
          len = $urandom_range(0, 20);
          send_frame(16'($urandom()), len, $urandom_range(0, 5 + len));
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 8);
        else if (pick < 95) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 300);
        send_frame(16'($urandom()), len, -1);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d stream bytes and %0d clears, checked %0d output items",
             bytes_sent, clears_sent, sb.n_checked);
    $display("%0d frames closed, %0d with empty body, %0d mismatches, %0d left over",
             sb.n_frames, sb.n_empty, sb.n_errors, sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lpd_pkg.sv
rtl/core/lpd_parser.sv
rtl/core/lpd_skid.sv
rtl/core/length_prefixed_deframer.sv
tb/length_prefixed_deframer_tb.sv
